### hdl/crtc_pkg.sv
// Shared types and constants of the cartridge real-time clock.
// No dependencies; the modules and the testbench of the block import this package.
`default_nettype none

package crtc_pkg;

   localparam int ACC_W = 23;
   localparam logic [ACC_W-1:0] CYCLES_PER_SECOND = 23'd4194304;

   localparam int LATCH_DEPTH = 5;

   // Register numbers as seen on the cartridge bus.
   localparam logic [7:0] REG_SECONDS  = 8'd8;
   localparam logic [7:0] REG_MINUTES  = 8'd9;
   localparam logic [7:0] REG_HOURS    = 8'd10;
   localparam logic [7:0] REG_DAY_LOW  = 8'd11;
   localparam logic [7:0] REG_DAY_HIGH = 8'd12;

   localparam logic [7:0] UNMAPPED_DATA = 8'hFF;
   localparam logic [7:0] DAY_HIGH_MASK = 8'hC1;

   localparam logic [5:0] SEC_LAST  = 6'd59;
   localparam logic [5:0] MIN_LAST  = 6'd59;
   localparam logic [4:0] HOUR_LAST = 5'd23;
   localparam logic [8:0] DAY_LAST  = 9'd511;

   // Bit positions inside the day-high register.
   localparam int DH_DAY8  = 0;
   localparam int DH_HALT  = 6;
   localparam int DH_CARRY = 7;

   localparam logic [7:0] LATCH_ARM  = 8'd0;
   localparam logic [7:0] LATCH_FIRE = 8'd1;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_LATCH = 2'd1,
      MODE_READ  = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  register_select;
      logic [7:0]  write_value;
      logic [15:0] tick_cycles;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } result_type;

endpackage

`default_nettype wire

### hdl/crtc_req_if.sv
// Request channel of the real-time clock: valid/ready handshake and item payload.
// Depends on nothing but plain logic types.
`default_nettype none

interface crtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  register_select;
   logic [7:0]  write_value;
   logic [15:0] tick_cycles;

   modport source (output valid, output mode, output register_select,
                   output write_value, output tick_cycles, input ready);
   modport sink (input valid, input mode, input register_select,
                 input write_value, input tick_cycles, output ready);
endinterface

`default_nettype wire

### hdl/crtc_rsp_if.sv
// Response channel of the real-time clock: valid/ready handshake and read data.
// Depends on nothing but plain logic types.
`default_nettype none

interface crtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink (input valid, input read_data, output ready);
endinterface

`default_nettype wire

### hdl/cartridge_rtc_registers.sv
// Cartridge real-time clock: tick, latch, register read and register write requests.
// A register read is held in the input register and its answer in the result register.
// Throughput: one request per cycle; the result register lets the next request in
// while a read answer waits, and only a read meeting a full, stalled result register stalls.
// Reset (synchronous): counters, prescaler, latch arm and latched copies clear to zero.
// Depends on crtc_pkg, crtc_req_if, crtc_rsp_if, crtc_in_stage, crtc_core, crtc_out_stage.
`default_nettype none

module cartridge_rtc_registers (
   input  wire logic   clock,
   input  wire logic   reset,
   crtc_req_if.sink    req_ch,
   crtc_rsp_if.source  rsp_ch
);
   import crtc_pkg::*;

   item_type   item;
   logic       fire;
   logic       out_free;
   result_type result;

   crtc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .item     (item),
      .fire     (fire)
   );

   crtc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .fire   (fire),
      .result (result)
   );

   crtc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

### hdl/crtc_in_stage.sv
// Input register of the real-time clock: holds one request until the core takes it.
// Depends on crtc_pkg and crtc_req_if.
`default_nettype none

module crtc_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   crtc_req_if.sink                req_ch,
   input  wire logic               out_free,
   output crtc_pkg::item_type      item,
   output logic                    fire
);
   import crtc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // A read needs room in the result register; every other request retires at once.
   assign fire = valid_ff && ((item_ff.mode != MODE_READ) || out_free);
   assign req_ch.ready = !valid_ff || fire;
   assign item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.ready) begin
         valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         item_ff.mode            <= mode_type'(req_ch.mode);
         item_ff.register_select <= req_ch.register_select;
         item_ff.write_value     <= req_ch.write_value;
         item_ff.tick_cycles     <= req_ch.tick_cycles;
      end
   end

endmodule

`default_nettype wire

### hdl/crtc_core.sv
// Clock state of the real-time clock: live counters, prescaler, latch and latched copies.
// Depends on crtc_pkg.
`default_nettype none

module crtc_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire crtc_pkg::item_type  item,
   input  wire logic                fire,
   output crtc_pkg::result_type     result
);
   import crtc_pkg::*;

   logic [5:0]       sec_ff, sec_in;
   logic [5:0]       min_ff, min_in;
   logic [4:0]       hour_ff, hour_in;
   logic [7:0]       day_low_ff, day_low_in;
   logic [7:0]       day_high_ff, day_high_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             armed_ff, armed_in;
   logic [7:0]       latched_ff [LATCH_DEPTH];
   logic             copy;

   logic [ACC_W-1:0] acc_sum;
   logic             sec_wrap, min_wrap, hour_wrap, day_wrap, roll_day;
   logic [8:0]       days, days_next;
   logic [5:0]       adv_sec, adv_min;
   logic [4:0]       adv_hour;
   logic [7:0]       adv_day_high;
   logic [7:0]       read_data;

   // One second's advance of the live counters, worked out from the current state.
   always_comb begin
      sec_wrap  = sec_ff == SEC_LAST;
      min_wrap  = min_ff == MIN_LAST;
      hour_wrap = hour_ff == HOUR_LAST;
      days      = {day_high_ff[DH_DAY8], day_low_ff};
      day_wrap  = days == DAY_LAST;
      roll_day  = sec_wrap && min_wrap && hour_wrap;
      adv_sec   = sec_wrap ? 6'd0 : sec_ff + 6'd1;
      adv_min   = !sec_wrap ? min_ff : (min_wrap ? 6'd0 : min_ff + 6'd1);
      adv_hour  = !(sec_wrap && min_wrap) ? hour_ff
                  : (hour_wrap ? 5'd0 : hour_ff + 5'd1);
      days_next = roll_day ? days + 9'd1 : days;
      adv_day_high = {day_high_ff[DH_CARRY] | (roll_day && day_wrap),
                      day_high_ff[DH_CARRY-1:DH_DAY8+1], days_next[8]};
      acc_sum   = acc_ff + {{(ACC_W-16){1'b0}}, item.tick_cycles};
   end

   always_comb begin
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      day_low_in  = day_low_ff;
      day_high_in = day_high_ff;
      acc_in      = acc_ff;
      armed_in    = armed_ff;
      copy        = 1'b0;
      if (fire) begin
         unique case (item.mode)
            MODE_TICK: begin
               if (!day_high_ff[DH_HALT]) begin
                  acc_in = acc_sum;
                  if (acc_sum >= CYCLES_PER_SECOND) begin
                     acc_in      = acc_sum - CYCLES_PER_SECOND;
                     sec_in      = adv_sec;
                     min_in      = adv_min;
                     hour_in     = adv_hour;
                     day_low_in  = days_next[7:0];
                     day_high_in = adv_day_high;
                  end
               end
            end
            MODE_LATCH: begin
               armed_in = item.write_value == LATCH_ARM;
               copy     = (item.write_value == LATCH_FIRE) && armed_ff;
            end
            MODE_READ: begin
            end
            MODE_WRITE: begin
               unique case (item.register_select)
                  REG_SECONDS:  sec_in      = item.write_value[5:0];
                  REG_MINUTES:  min_in      = item.write_value[5:0];
                  REG_HOURS:    hour_in     = item.write_value[4:0];
                  REG_DAY_LOW:  day_low_in  = item.write_value;
                  REG_DAY_HIGH: day_high_in = item.write_value & DAY_HIGH_MASK;
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (item.register_select)
         REG_SECONDS:  read_data = latched_ff[0];
         REG_MINUTES:  read_data = latched_ff[1];
         REG_HOURS:    read_data = latched_ff[2];
         REG_DAY_LOW:  read_data = latched_ff[3];
         REG_DAY_HIGH: read_data = latched_ff[4];
         default:      read_data = UNMAPPED_DATA;
      endcase
      result.valid = fire && (item.mode == MODE_READ);
      result.data  = read_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff      <= '0;
         min_ff      <= '0;
         hour_ff     <= '0;
         day_low_ff  <= '0;
         day_high_ff <= '0;
         acc_ff      <= '0;
         armed_ff    <= 1'b0;
         for (int i = 0; i < LATCH_DEPTH; i++) begin
            latched_ff[i] <= '0;
         end
      end else begin
         sec_ff      <= sec_in;
         min_ff      <= min_in;
         hour_ff     <= hour_in;
         day_low_ff  <= day_low_in;
         day_high_ff <= day_high_in;
         acc_ff      <= acc_in;
         armed_ff    <= armed_in;
         if (copy) begin
            latched_ff[0] <= {2'b00, sec_ff};
            latched_ff[1] <= {2'b00, min_ff};
            latched_ff[2] <= {3'b000, hour_ff};
            latched_ff[3] <= day_low_ff;
            latched_ff[4] <= day_high_ff;
         end
      end
   end

   a_acc_below_second: assert property (@(posedge clock) disable iff (reset)
      acc_ff < CYCLES_PER_SECOND)
      else $error("prescaler holds a full second or more");

   a_day_high_unused_zero: assert property (@(posedge clock) disable iff (reset)
      day_high_ff[DH_CARRY-2:DH_DAY8+1] == '0)
      else $error("unimplemented day-high bits are set");

   a_halt_freezes_prescaler: assert property (@(posedge clock) disable iff (reset)
      fire && (item.mode == MODE_TICK) && day_high_ff[DH_HALT] |=> $stable(acc_ff))
      else $error("prescaler moved while the clock was halted");

   a_carry_sticky: assert property (@(posedge clock) disable iff (reset)
      day_high_ff[DH_CARRY] &&
      !(fire && (item.mode == MODE_WRITE) && (item.register_select == REG_DAY_HIGH))
      |=> day_high_ff[DH_CARRY])
      else $error("day carry cleared without a day-high write");

endmodule

`default_nettype wire

### hdl/crtc_out_stage.sv
// Result register of the real-time clock: holds read data until the response is taken.
// Depends on crtc_pkg and crtc_rsp_if.
`default_nettype none

module crtc_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crtc_pkg::result_type  result,
   output logic                       out_free,
   crtc_rsp_if.source                 rsp_ch
);
   import crtc_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.read_data = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result.valid) begin
         data_ff <= result.data;
      end
   end

endmodule

`default_nettype wire

### tb/cartridge_rtc_registers_test.sv
`timescale 1ns / 1ps
// Testbench of cartridge_rtc_registers: tick, latch, read and write requests are driven
// through the request channel and every read answer is checked against a shadow clock.
// Depends on crtc_pkg, crtc_req_if, crtc_rsp_if and the block itself.

module cartridge_rtc_registers_test;
   import crtc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 760;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned HOLD_CYCLES  = 300;

   // Shadow copy of the clock registers; it holds the read answers still owed by the block.
   class rtc_shadow;
      logic [5:0]       seconds;
      logic [5:0]       minutes;
      logic [4:0]       hours;
      logic [7:0]       day_low;
      logic [7:0]       day_high;
      logic [7:0]       latched [LATCH_DEPTH];
      bit               armed;
      logic [ACC_W-1:0] prescaler;
      int unsigned      seconds_advanced;
      int unsigned      errors;
      logic [7:0]       reads_due [$];

      function new();
         seconds = '0;
         minutes = '0;
         hours = '0;
         day_low = '0;
         day_high = '0;
         foreach (latched[i]) latched[i] = '0;
         armed = 1'b0;
         prescaler = '0;
         seconds_advanced = 0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return reads_due.size();
      endfunction

      function void note_request(input item_type it);
         logic [ACC_W-1:0] sum;
         logic [8:0]       days;
         logic [2:0]       slot;
         case (it.mode)
            MODE_TICK: begin
               if (!day_high[DH_HALT]) begin
                  sum = prescaler + ACC_W'(it.tick_cycles);
                  if (sum >= CYCLES_PER_SECOND) begin
                     prescaler = sum - CYCLES_PER_SECOND;
                     seconds_advanced++;
                     // Counters above their limit run up to the mask and wrap without carry.
                     if (seconds != SEC_LAST) begin
                        seconds = seconds + 6'd1;
                     end else begin
                        seconds = '0;
                        if (minutes != MIN_LAST) begin
                           minutes = minutes + 6'd1;
                        end else begin
                           minutes = '0;
                           if (hours != HOUR_LAST) begin
                              hours = hours + 5'd1;
                           end else begin
                              hours = '0;
                              days = {day_high[DH_DAY8], day_low};
                              if (days != DAY_LAST) begin
                                 days = days + 9'd1;
                              end else begin
                                 days = '0;
                                 day_high[DH_CARRY] = 1'b1;
                              end
                              day_low = days[7:0];
                              day_high[DH_DAY8] = days[8];
                           end
                        end
                     end
                  end else begin
                     prescaler = sum;
                  end
               end
            end
            MODE_LATCH: begin
               if (it.write_value == LATCH_ARM) begin
                  armed = 1'b1;
               end else if (it.write_value == LATCH_FIRE && armed) begin
                  latched[0] = 8'(seconds);
                  latched[1] = 8'(minutes);
                  latched[2] = 8'(hours);
                  latched[3] = day_low;
                  latched[4] = day_high;
                  armed = 1'b0;
               end else begin
                  armed = 1'b0;
               end
            end
            MODE_READ: begin
               if (it.register_select >= REG_SECONDS && it.register_select <= REG_DAY_HIGH) begin
                  slot = 3'(it.register_select - REG_SECONDS);
                  reads_due = {reads_due, latched[slot]};
               end else begin
                  reads_due = {reads_due, UNMAPPED_DATA};
               end
            end
            MODE_WRITE: begin
               case (it.register_select)
                  REG_SECONDS:  seconds = it.write_value[5:0];
                  REG_MINUTES:  minutes = it.write_value[5:0];
                  REG_HOURS:    hours = it.write_value[4:0];
                  REG_DAY_LOW:  day_low = it.write_value;
                  REG_DAY_HIGH: day_high = it.write_value & DAY_HIGH_MASK;
                  default: ;
               endcase
            end
         endcase
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_read(input logic [7:0] got);
         logic [7:0] want;
         if (reads_due.size() == 0) begin
            report_mismatch($sformatf("read data %02h arrived with no read pending", got));
         end else begin
            want = reads_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("read data %02h, expected %02h", got, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   rtc_shadow   shadow;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   bit          hold_off = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;

   crtc_req_if req_ch ();
   crtc_rsp_if rsp_ch ();

   cartridge_rtc_registers dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: checks each accepted answer, then decides whether to take the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_read(rsp_ch.read_data);
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(input mode_type m, input logic [7:0] sel, input logic [7:0] value,
                       input logic [15:0] cycles);
      item_type it;
      it.mode = m;
      it.register_select = sel;
      it.write_value = value;
      it.tick_cycles = cycles;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.register_select <= sel;
      req_ch.write_value <= value;
      req_ch.tick_cycles <= cycles;
      do @(posedge clock); while (!req_ch.ready);
      shadow.note_request(it);
      items_sent++;
   endtask

   task automatic tick(input logic [15:0] cycles);
      send(MODE_TICK, 8'h00, 8'h00, cycles);
   endtask

   task automatic latch(input logic [7:0] value);
      send(MODE_LATCH, 8'h00, value, 16'h0000);
   endtask

   task automatic read_reg(input logic [7:0] sel);
      send(MODE_READ, sel, 8'h00, 16'h0000);
   endtask

   task automatic write_reg(input logic [7:0] sel, input logic [7:0] value);
      send(MODE_WRITE, sel, value, 16'h0000);
   endtask

   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // One sequence: preset the counters, tick until a second goes by or a tick cap is reached, latch, read back.
   task automatic run_scenario(input int unsigned kind);
      int unsigned start;
      int unsigned ticks;
      int unsigned cap;
      int unsigned pick;
      case (kind)
         0: begin
            // Full rollover: 23:59:59 on day 511 wraps the day count and sets the carry.
            write_reg(REG_SECONDS, {2'($urandom), SEC_LAST});
            write_reg(REG_MINUTES, {2'($urandom), MIN_LAST});
            write_reg(REG_HOURS, {3'($urandom), HOUR_LAST});
            write_reg(REG_DAY_LOW, 8'hFF);
            write_reg(REG_DAY_HIGH, (8'($urandom) & ~8'h40) | 8'h01);
         end
         1: begin
            write_reg(REG_SECONDS, {2'($urandom), SEC_LAST});
            write_reg(REG_MINUTES, {2'($urandom), MIN_LAST});
            write_reg(REG_HOURS, {3'($urandom), HOUR_LAST});
            write_reg(REG_DAY_LOW, 8'($urandom));
            write_reg(REG_DAY_HIGH, 8'($urandom) & ~8'h40);
         end
         2: begin
            write_reg(REG_SECONDS, {2'($urandom), SEC_LAST});
            write_reg(REG_MINUTES, 8'($urandom));
            write_reg(REG_HOURS, 8'($urandom));
         end
         3: begin
            pick = $urandom_range(2);
            if (pick == 0) begin
               write_reg(REG_SECONDS, {2'($urandom), 6'($urandom_range(63, 60))});
            end else if (pick == 1) begin
               write_reg(REG_SECONDS, {2'($urandom), SEC_LAST});
               write_reg(REG_MINUTES, {2'($urandom), 6'($urandom_range(63, 60))});
            end else begin
               write_reg(REG_SECONDS, {2'($urandom), SEC_LAST});
               write_reg(REG_MINUTES, {2'($urandom), MIN_LAST});
               write_reg(REG_HOURS, {3'($urandom), 5'($urandom_range(31, 24))});
            end
         end
         4: begin
            repeat ($urandom_range(5, 1))
               write_reg(8'($urandom_range(REG_DAY_HIGH, REG_SECONDS)), 8'($urandom));
         end
         default: begin
            write_reg(REG_DAY_HIGH, 8'($urandom) | 8'h40);
         end
      endcase

      cap = shadow.day_high[DH_HALT] ? 6 : 90;
      start = shadow.seconds_advanced;
      ticks = 0;
      while (shadow.seconds_advanced == start && ticks < cap) begin
         if ($urandom_range(99) < 8) begin
            send(mode_type'($urandom_range(3)), 8'($urandom), 8'($urandom), 16'($urandom));
         end else begin
            if ($urandom_range(99) < 75)
               tick(16'($urandom_range(65535, 57344)));
            else
               tick(16'($urandom));
            ticks++;
         end
      end
      if (shadow.day_high[DH_HALT])
         write_reg(REG_DAY_HIGH, 8'($urandom) & ~8'h40);

      pick = $urandom_range(9);
      if (pick < 7) begin
         latch(LATCH_ARM);
         latch(LATCH_FIRE);
      end else if (pick == 7) begin
         latch(LATCH_FIRE);
      end else if (pick == 8) begin
         latch(LATCH_ARM);
         latch(8'($urandom_range(255, 2)));
         latch(LATCH_FIRE);
      end else begin
         latch(LATCH_ARM);
         latch(LATCH_ARM);
         latch(LATCH_FIRE);
      end
      read_reg(REG_SECONDS);
      read_reg(REG_MINUTES);
      read_reg(REG_HOURS);
      read_reg(REG_DAY_LOW);
      read_reg(REG_DAY_HIGH);
      read_reg(8'($urandom));
   endtask

   initial begin
      int unsigned base;
      int unsigned n;
      shadow = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_TICK;
      req_ch.register_select <= 8'h00;
      req_ch.write_value <= 8'h00;
      req_ch.tick_cycles <= 16'h0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reads straight after reset, mapped and unmapped.
      read_reg(REG_SECONDS);
      read_reg(8'h00);
      read_reg(8'hFF);
      // Writes of all ones show the masks; day high also sets the halt bit.
      write_reg(REG_SECONDS, 8'hFF);
      write_reg(REG_MINUTES, 8'hFF);
      write_reg(REG_HOURS, 8'hFF);
      write_reg(REG_DAY_LOW, 8'hFF);
      write_reg(REG_DAY_HIGH, 8'hFF);
      write_reg(8'h07, 8'hAA);
      write_reg(8'hFF, 8'h00);
      tick(16'hFFFF);
      tick(16'h0000);
      // A fire without arming, and an arm broken by another byte, copy nothing.
      latch(LATCH_FIRE);
      latch(LATCH_ARM);
      latch(8'h02);
      latch(LATCH_FIRE);
      read_reg(REG_SECONDS);
      latch(LATCH_ARM);
      latch(LATCH_FIRE);
      read_reg(REG_SECONDS);
      read_reg(REG_MINUTES);
      read_reg(REG_HOURS);
      read_reg(REG_DAY_LOW);
      read_reg(REG_DAY_HIGH);
      read_reg(8'd13);
      write_reg(REG_DAY_HIGH, 8'h00);
      tick(16'hFFFF);

      // Long hold-off on the result side while reads keep coming, so the input stalls.
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      repeat (20) read_reg(8'($urandom_range(13, 7)));
      wait_for_answers();

      // The first two sequences are a full day rollover and an out-of-range counter.
      base = items_sent;
      n = 0;
      while (items_sent < base + RANDOM_ITEMS) begin
         case (n % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 82; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 82; end
            default: begin gap_pct = 30; stall_pct = 30; end
         endcase
         if (n == 0)
            run_scenario(0);
         else if (n == 1)
            run_scenario(3);
         else
            run_scenario($urandom_range(5));
         n++;
      end

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
hdl/crtc_pkg.sv
hdl/crtc_req_if.sv
hdl/crtc_rsp_if.sv
hdl/crtc_in_stage.sv
hdl/crtc_core.sv
hdl/crtc_out_stage.sv
hdl/cartridge_rtc_registers.sv
tb/cartridge_rtc_registers_test.sv
